[hw/rtl/sdt_pkg.sv]
// ============================================================================
// sdt_pkg - shared definitions for the socket demultiplexing table
// Table depths, derived index and count widths, operation and status codes,
// and the layout of one entry in each table.
// ============================================================================
package sdt_pkg;

   localparam int LISTEN_DEPTH = 16;
   localparam int ESTAB_DEPTH  = 64;

   localparam int LISTEN_AW = (LISTEN_DEPTH > 1) ? $clog2(LISTEN_DEPTH) : 1;
   localparam int ESTAB_AW  = (ESTAB_DEPTH > 1) ? $clog2(ESTAB_DEPTH) : 1;
   localparam int LISTEN_CW = $clog2(LISTEN_DEPTH + 1);
   localparam int ESTAB_CW  = $clog2(ESTAB_DEPTH + 1);
   localparam int SCAN_CW   = (LISTEN_CW > ESTAB_CW) ? LISTEN_CW : ESTAB_CW;

   typedef enum logic [2:0] {
      FN_ADD_L     = 3'd0,
      FN_ADD_E     = 3'd1,
      FN_DEL_L     = 3'd2,
      FN_DEL_E     = 3'd3,
      FN_LOOKUP_L  = 3'd4,
      FN_LOOKUP_E  = 3'd5,
      FN_REPLACE_E = 3'd6
   } func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EXISTS   = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic [15:0] handle;
      logic [31:0] addr;
      logic [15:0] port;
   } listen_entry_type;

   typedef struct packed {
      logic [15:0] handle;
      logic [31:0] local_addr;
      logic [15:0] local_port;
      logic [31:0] remote_addr;
      logic [15:0] remote_port;
   } estab_entry_type;

endpackage

[hw/rtl/socket_demux_table_core.sv]
// ============================================================================
// socket_demux_table_core - listener and established socket lookup tables
// Two insertion-ordered tables with add, delete, lookup and replace, walked
// one entry per cycle by a single compare unit under a small sequencer.
// ============================================================================
// One operation is taken at a time: req_ready is high only while the
// sequencer is idle, and every accepted transfer gives exactly one response
// transfer. A lookup or a duplicate check walks its table from the oldest
// entry, one memory read per cycle. A delete walks the same way up to the
// hit and then closes the gap from there, moving one entry per cycle. An
// add writes the new entry in the ADD state, and the response is loaded in
// the RESP state. The longest operation is a replace that deletes from a
// full established table and then adds again; after RESP the sequencer
// returns to IDLE before the next request is taken. The walks go one entry
// at a time because each table memory has a single read port. A new
// request is taken while the previous response still waits on rsp_ready;
// a second finished result waits inside until the output register is free.
module socket_demux_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [15:0] req_handle,
   input  logic [15:0] req_old_handle,
   input  logic [31:0] req_local_addr,
   input  logic [15:0] req_local_port,
   input  logic [31:0] req_remote_addr,
   input  logic [15:0] req_remote_port,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_found_handle
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_ADD,
      S_RESP
   } state_type;

   // sequencer and control
   state_type                      state_ff, state_in;
   logic [sdt_pkg::SCAN_CW-1:0]    addr_ff, addr_in;
   logic                           pend_ff, pend_in;
   logic [sdt_pkg::SCAN_CW-1:0]    pend_idx_ff, pend_idx_in;
   logic [sdt_pkg::LISTEN_CW-1:0]  listen_count_ff, listen_count_in;
   logic [sdt_pkg::ESTAB_CW-1:0]   estab_count_ff, estab_count_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // request and result payload
   sdt_pkg::func_type              func_ff, func_in;
   logic [15:0]                    handle_ff, handle_in;
   logic [15:0]                    old_handle_ff, old_handle_in;
   logic [31:0]                    local_addr_ff, local_addr_in;
   logic [15:0]                    local_port_ff, local_port_in;
   logic [31:0]                    remote_addr_ff, remote_addr_in;
   logic [15:0]                    remote_port_ff, remote_port_in;
   sdt_pkg::status_type            res_status_ff, res_status_in;
   logic [15:0]                    res_found_ff, res_found_in;
   sdt_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [15:0]                    rsp_found_ff, rsp_found_in;

   // table memories
   sdt_pkg::listen_entry_type      listen_mem [sdt_pkg::LISTEN_DEPTH];
   sdt_pkg::estab_entry_type       estab_mem  [sdt_pkg::ESTAB_DEPTH];
   sdt_pkg::listen_entry_type      l_rd_ff;
   sdt_pkg::estab_entry_type       e_rd_ff;
   logic                           l_we, e_we;
   logic [sdt_pkg::LISTEN_AW-1:0]  l_wa;
   logic [sdt_pkg::ESTAB_AW-1:0]   e_wa;
   sdt_pkg::listen_entry_type      l_wd;
   sdt_pkg::estab_entry_type       e_wd;

   // shared compare unit and helpers
   logic                           is_listen;
   logic [sdt_pkg::SCAN_CW-1:0]    cur_count;
   logic                           scan_more;
   logic [15:0]                    key_handle;
   logic                           match;
   logic                           hit;
   logic [sdt_pkg::SCAN_CW-1:0]    pend_idx_m1;
   logic                           listen_full, estab_full;
   logic                           req_xfer;

   assign req_ready        = (state_ff == S_IDLE);
   assign req_xfer         = req_valid && req_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found_handle = rsp_found_ff;

   // Operation decides which table the walk runs over.
   always_comb begin
      unique case (func_ff) inside
         sdt_pkg::FN_ADD_L, sdt_pkg::FN_DEL_L, sdt_pkg::FN_LOOKUP_L: is_listen = 1'b1;
         default: is_listen = 1'b0;
      endcase
   end

   assign cur_count   = is_listen ? sdt_pkg::SCAN_CW'(listen_count_ff)
                                  : sdt_pkg::SCAN_CW'(estab_count_ff);
   assign scan_more   = (addr_ff < cur_count);
   assign key_handle  = (func_ff == sdt_pkg::FN_REPLACE_E) ? old_handle_ff : handle_ff;
   assign pend_idx_m1 = pend_idx_ff - sdt_pkg::SCAN_CW'(1);
   assign listen_full = (listen_count_ff >= sdt_pkg::LISTEN_CW'(sdt_pkg::LISTEN_DEPTH));
   assign estab_full  = (estab_count_ff >= sdt_pkg::ESTAB_CW'(sdt_pkg::ESTAB_DEPTH));

   // Compare the entry read last cycle against the key of this operation.
   // A listener stored with address zero matches any destination address.
   always_comb begin
      unique case (func_ff) inside
         sdt_pkg::FN_ADD_L, sdt_pkg::FN_LOOKUP_L:
            match = (l_rd_ff.port == local_port_ff) &&
                    ((l_rd_ff.addr == 32'd0) || (l_rd_ff.addr == local_addr_ff));
         sdt_pkg::FN_DEL_L:
            match = (l_rd_ff.handle == key_handle);
         sdt_pkg::FN_DEL_E, sdt_pkg::FN_REPLACE_E:
            match = (e_rd_ff.handle == key_handle);
         sdt_pkg::FN_LOOKUP_E:
            match = (e_rd_ff.local_addr  == local_addr_ff)  &&
                    (e_rd_ff.local_port  == local_port_ff)  &&
                    (e_rd_ff.remote_addr == remote_addr_ff) &&
                    (e_rd_ff.remote_port == remote_port_ff);
         default:
            match = 1'b0;
      endcase
   end

   assign hit = pend_ff && match;

   // Memory write port: gap closing in SHIFT, append in ADD.
   always_comb begin
      l_we = 1'b0;
      e_we = 1'b0;
      l_wa = pend_idx_m1[sdt_pkg::LISTEN_AW-1:0];
      e_wa = pend_idx_m1[sdt_pkg::ESTAB_AW-1:0];
      l_wd = l_rd_ff;
      e_wd = e_rd_ff;
      if (state_ff == S_SHIFT && pend_ff) begin
         l_we = is_listen;
         e_we = !is_listen;
      end else if (state_ff == S_ADD) begin
         if (is_listen) begin
            l_we = !listen_full;
            l_wa = listen_count_ff[sdt_pkg::LISTEN_AW-1:0];
            l_wd = '{handle: handle_ff, addr: local_addr_ff, port: local_port_ff};
         end else begin
            e_we = !estab_full && (handle_ff != 16'd0);
            e_wa = estab_count_ff[sdt_pkg::ESTAB_AW-1:0];
            e_wd = '{handle: handle_ff, local_addr: local_addr_ff,
                     local_port: local_port_ff, remote_addr: remote_addr_ff,
                     remote_port: remote_port_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (l_we) begin
         listen_mem[l_wa] <= l_wd;
      end
      l_rd_ff <= listen_mem[addr_ff[sdt_pkg::LISTEN_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (e_we) begin
         estab_mem[e_wa] <= e_wd;
      end
      e_rd_ff <= estab_mem[addr_ff[sdt_pkg::ESTAB_AW-1:0]];
   end

   // Sequencer next state.
   always_comb begin
      state_in        = state_ff;
      addr_in         = addr_ff;
      pend_in         = pend_ff;
      pend_idx_in     = pend_idx_ff;
      listen_count_in = listen_count_ff;
      estab_count_in  = estab_count_ff;
      rsp_valid_in    = rsp_valid_ff;
      func_in         = func_ff;
      handle_in       = handle_ff;
      old_handle_in   = old_handle_ff;
      local_addr_in   = local_addr_ff;
      local_port_in   = local_port_ff;
      remote_addr_in  = remote_addr_ff;
      remote_port_in  = remote_port_ff;
      res_status_in   = res_status_ff;
      res_found_in    = res_found_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_found_in    = rsp_found_ff;

      // drop the response once its transfer completes
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               func_in        = sdt_pkg::func_type'(req_func);
               handle_in      = req_handle;
               old_handle_in  = req_old_handle;
               local_addr_in  = req_local_addr;
               local_port_in  = req_local_port;
               remote_addr_in = req_remote_addr;
               remote_port_in = req_remote_port;
               addr_in        = '0;
               pend_in        = 1'b0;
               res_status_in  = sdt_pkg::ST_OK;
               res_found_in   = 16'd0;
               unique case (req_func) inside
                  sdt_pkg::FN_ADD_L:
                     state_in = (req_handle == 16'd0) ? S_RESP : S_SCAN;
                  sdt_pkg::FN_ADD_E:
                     state_in = S_ADD;
                  sdt_pkg::FN_DEL_L, sdt_pkg::FN_DEL_E: begin
                     if (req_handle == 16'd0) begin
                        res_status_in = sdt_pkg::ST_NOTFOUND;
                        state_in      = S_RESP;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  sdt_pkg::FN_LOOKUP_L, sdt_pkg::FN_LOOKUP_E:
                     state_in = S_SCAN;
                  sdt_pkg::FN_REPLACE_E:
                     state_in = (req_old_handle == 16'd0) ? S_ADD : S_SCAN;
                  default:
                     state_in = S_RESP;
               endcase
            end
         end

         S_SCAN: begin
            // issue the next read while comparing the previous one
            if (scan_more) begin
               addr_in     = addr_ff + sdt_pkg::SCAN_CW'(1);
               pend_in     = 1'b1;
               pend_idx_in = addr_ff;
            end else begin
               pend_in = 1'b0;
            end
            if (hit) begin
               pend_in = 1'b0;
               unique case (func_ff) inside
                  sdt_pkg::FN_ADD_L: begin
                     res_status_in = sdt_pkg::ST_EXISTS;
                     state_in      = S_RESP;
                  end
                  sdt_pkg::FN_LOOKUP_L: begin
                     res_found_in = l_rd_ff.handle;
                     state_in     = S_RESP;
                  end
                  sdt_pkg::FN_LOOKUP_E: begin
                     res_found_in = e_rd_ff.handle;
                     state_in     = S_RESP;
                  end
                  default: begin
                     // delete: close the gap from the entry after the hit
                     addr_in  = pend_idx_ff + sdt_pkg::SCAN_CW'(1);
                     state_in = S_SHIFT;
                  end
               endcase
            end else if (!scan_more && !pend_ff) begin
               unique case (func_ff) inside
                  sdt_pkg::FN_ADD_L, sdt_pkg::FN_REPLACE_E:
                     state_in = S_ADD;
                  default: begin
                     res_status_in = sdt_pkg::ST_NOTFOUND;
                     state_in      = S_RESP;
                  end
               endcase
            end
         end

         S_SHIFT: begin
            if (scan_more) begin
               addr_in     = addr_ff + sdt_pkg::SCAN_CW'(1);
               pend_in     = 1'b1;
               pend_idx_in = addr_ff;
            end else begin
               pend_in = 1'b0;
            end
            if (!scan_more && !pend_ff) begin
               if (is_listen) begin
                  listen_count_in = listen_count_ff - sdt_pkg::LISTEN_CW'(1);
               end else begin
                  estab_count_in = estab_count_ff - sdt_pkg::ESTAB_CW'(1);
               end
               state_in = (func_ff == sdt_pkg::FN_REPLACE_E) ? S_ADD : S_RESP;
            end
         end

         S_ADD: begin
            if (is_listen) begin
               if (listen_full) begin
                  res_status_in = sdt_pkg::ST_FULL;
               end else begin
                  listen_count_in = listen_count_ff + sdt_pkg::LISTEN_CW'(1);
               end
            end else if (handle_ff != 16'd0) begin
               if (estab_full) begin
                  res_status_in = sdt_pkg::ST_FULL;
               end else begin
                  estab_count_in = estab_count_ff + sdt_pkg::ESTAB_CW'(1);
               end
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         addr_ff         <= '0;
         pend_ff         <= 1'b0;
         pend_idx_ff     <= '0;
         listen_count_ff <= '0;
         estab_count_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         addr_ff         <= addr_in;
         pend_ff         <= pend_in;
         pend_idx_ff     <= pend_idx_in;
         listen_count_ff <= listen_count_in;
         estab_count_ff  <= estab_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      func_ff        <= func_in;
      handle_ff      <= handle_in;
      old_handle_ff  <= old_handle_in;
      local_addr_ff  <= local_addr_in;
      local_port_ff  <= local_port_in;
      remote_addr_ff <= remote_addr_in;
      remote_port_ff <= remote_port_in;
      res_status_ff  <= res_status_in;
      res_found_ff   <= res_found_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_found_ff   <= rsp_found_in;
   end

endmodule

[tb/sv/tb_socket_demux_table_core.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_socket_demux_table_core - self-checking bench for the socket demux table
// A short table of directed operations, followed by random traffic in fill,
// balanced and drain phases. An in-bench model of both tables predicts every
// response. Both handshakes are throttled at random.
// ============================================================================
module tb_socket_demux_table_core;

   // func code seven is not in the package enum; it must leave the tables alone
   localparam logic [2:0] FN_UNUSED = 3'd7;

   localparam int RAND_ITEMS     = 830;
   localparam int SEG_LEN        = 140;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 2 * sdt_pkg::ESTAB_DEPTH + 32;

   typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} traffic_mix_type;

   typedef struct packed {
      logic [2:0]          func;
      logic [15:0]         handle;
      logic [15:0]         old_handle;
      logic [31:0]         local_addr;
      logic [15:0]         local_port;
      logic [31:0]         remote_addr;
      logic [15:0]         remote_port;
      logic                typed;       // response given in the row itself
      sdt_pkg::status_type status;
      logic [15:0]         found_handle;
   } socket_op_type;

   typedef struct packed {
      sdt_pkg::status_type status;
      logic [15:0]         found_handle;
   } socket_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_func = sdt_pkg::FN_LOOKUP_L;
   logic [15:0] req_handle = '0;
   logic [15:0] req_old_handle = '0;
   logic [31:0] req_local_addr = '0;
   logic [15:0] req_local_port = '0;
   logic [31:0] req_remote_addr = '0;
   logic [15:0] req_remote_port = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_found_handle;

   socket_demux_table_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_handle       (req_handle),
      .req_old_handle   (req_old_handle),
      .req_local_addr   (req_local_addr),
      .req_local_port   (req_local_port),
      .req_remote_addr  (req_remote_addr),
      .req_remote_port  (req_remote_port),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_found_handle (rsp_found_handle)
   );

   // 2 ns period: high for 1 ns, low for 1 ns
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Shadow tables, kept in insertion order exactly as the block keeps them
   // -------------------------------------------------------------------------
   sdt_pkg::listen_entry_type listen_shadow [sdt_pkg::LISTEN_DEPTH];
   sdt_pkg::estab_entry_type  estab_shadow  [sdt_pkg::ESTAB_DEPTH];
   int                        listen_used = 0;
   int                        estab_used  = 0;

   socket_rsp_type   pending_rsp [$];
   socket_op_type    directed_ops [$];
   int               error_count = 0;
   int               idle_cycles = 0;

   // First listener whose port matches and whose address is wildcard or equal
   function automatic int listen_match(logic [31:0] addr, logic [15:0] port);
      for (int i = 0; i < listen_used; i++) begin
         if (listen_shadow[i].port == port &&
             (listen_shadow[i].addr == '0 || listen_shadow[i].addr == addr))
            return i;
      end
      return -1;
   endfunction

   function automatic int estab_match(socket_op_type op);
      for (int i = 0; i < estab_used; i++) begin
         if (estab_shadow[i].local_addr == op.local_addr &&
             estab_shadow[i].local_port == op.local_port &&
             estab_shadow[i].remote_addr == op.remote_addr &&
             estab_shadow[i].remote_port == op.remote_port)
            return i;
      end
      return -1;
   endfunction

   // Drop the oldest listener with this handle and close the gap
   function automatic sdt_pkg::status_type listen_remove(logic [15:0] handle);
      if (handle == '0)
         return sdt_pkg::ST_NOTFOUND;
      for (int i = 0; i < listen_used; i++) begin
         if (listen_shadow[i].handle == handle) begin
            for (int j = i; j + 1 < listen_used; j++)
               listen_shadow[j] = listen_shadow[j + 1];
            listen_used--;
            return sdt_pkg::ST_OK;
         end
      end
      return sdt_pkg::ST_NOTFOUND;
   endfunction

   function automatic sdt_pkg::status_type estab_remove(logic [15:0] handle);
      if (handle == '0)
         return sdt_pkg::ST_NOTFOUND;
      for (int i = 0; i < estab_used; i++) begin
         if (estab_shadow[i].handle == handle) begin
            for (int j = i; j + 1 < estab_used; j++)
               estab_shadow[j] = estab_shadow[j + 1];
            estab_used--;
            return sdt_pkg::ST_OK;
         end
      end
      return sdt_pkg::ST_NOTFOUND;
   endfunction

   function automatic sdt_pkg::status_type estab_insert(socket_op_type op);
      if (op.handle == '0)
         return sdt_pkg::ST_OK;
      if (estab_used >= sdt_pkg::ESTAB_DEPTH)
         return sdt_pkg::ST_FULL;
      estab_shadow[estab_used] = {op.handle, op.local_addr, op.local_port,
                                  op.remote_addr, op.remote_port};
      estab_used++;
      return sdt_pkg::ST_OK;
   endfunction

   // Apply one operation to the shadow tables and return its response
   function automatic socket_rsp_type socket_lookup_predict(socket_op_type op);
      socket_rsp_type rsp;
      int             hit;
      rsp.status       = sdt_pkg::ST_OK;
      rsp.found_handle = '0;
      case (op.func)
         sdt_pkg::FN_ADD_L: begin
            if (op.handle != '0) begin
               if (listen_match(op.local_addr, op.local_port) >= 0)
                  rsp.status = sdt_pkg::ST_EXISTS;
               else if (listen_used >= sdt_pkg::LISTEN_DEPTH)
                  rsp.status = sdt_pkg::ST_FULL;
               else begin
                  listen_shadow[listen_used] = {op.handle, op.local_addr, op.local_port};
                  listen_used++;
               end
            end
         end
         sdt_pkg::FN_ADD_E:    rsp.status = estab_insert(op);
         sdt_pkg::FN_DEL_L:    rsp.status = listen_remove(op.handle);
         sdt_pkg::FN_DEL_E:    rsp.status = estab_remove(op.handle);
         sdt_pkg::FN_LOOKUP_L: begin
            hit = listen_match(op.local_addr, op.local_port);
            if (hit >= 0)
               rsp.found_handle = listen_shadow[hit].handle;
            else
               rsp.status = sdt_pkg::ST_NOTFOUND;
         end
         sdt_pkg::FN_LOOKUP_E: begin
            hit = estab_match(op);
            if (hit >= 0)
               rsp.found_handle = estab_shadow[hit].handle;
            else
               rsp.status = sdt_pkg::ST_NOTFOUND;
         end
         sdt_pkg::FN_REPLACE_E: begin
            // a miss on the old handle does not affect the status
            if (op.old_handle != '0)
               void'(estab_remove(op.old_handle));
            rsp.status = estab_insert(op);
         end
         default: ;
      endcase
      return rsp;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus construction
   // -------------------------------------------------------------------------
   function automatic socket_op_type mk_op(logic [2:0] func, logic [15:0] handle,
                                           logic [15:0] old_handle, logic [31:0] la,
                                           logic [15:0] lp, logic [31:0] ra,
                                           logic [15:0] rp, logic typed,
                                           sdt_pkg::status_type status,
                                           logic [15:0] found);
      socket_op_type op;
      op = {func, handle, old_handle, la, lp, ra, rp, typed, status, found};
      return op;
   endfunction

   // Mostly small handles so that duplicates and deletes of live ones are common
   function automatic logic [15:0] pick_handle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)  return '0;
      if (r < 10) return 16'hFFFF;
      if (r < 20) return 16'($urandom);
      return 16'($urandom_range(1, 24));
   endfunction

   function automatic logic [31:0] pick_addr();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return '0;
      if (r < 25) return 32'hFFFF_FFFF;
      if (r < 40) return $urandom;
      case ($urandom_range(0, 2))
         0:       return 32'h0A00_0001;
         1:       return 32'h0A00_0002;
         default: return 32'hC0A8_0001;
      endcase
   endfunction

   function automatic logic [15:0] pick_port();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return '0;
      if (r < 25) return 16'hFFFF;
      if (r < 40) return 16'($urandom);
      case ($urandom_range(0, 2))
         0:       return 16'd80;
         1:       return 16'd443;
         default: return 16'd8080;
      endcase
   endfunction

   // Random operation; live entries are reused so lookups and deletes hit
   function automatic socket_op_type gen_socket_op(traffic_mix_type mix);
      socket_op_type op;
      int            r;
      int            idx;
      logic          reuse;
      // every request field starts fully random; unused ones stay that way as noise
      op = {3'($urandom_range(0, 6)), 16'($urandom), 16'($urandom), 32'($urandom),
            16'($urandom), 32'($urandom), 16'($urandom), 1'b0, sdt_pkg::ST_OK, 16'h0};
      if ($urandom_range(0, 99) < 8)
         return op;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: op.func = (r < 25) ? sdt_pkg::FN_ADD_L :
                             (r < 80) ? sdt_pkg::FN_ADD_E :
                             (r < 90) ? sdt_pkg::FN_REPLACE_E :
                             (r < 95) ? sdt_pkg::FN_LOOKUP_L :
                             sdt_pkg::FN_LOOKUP_E;
         MIX_DRAIN: op.func = (r < 5)  ? sdt_pkg::FN_ADD_L :
                              (r < 10) ? sdt_pkg::FN_ADD_E :
                              (r < 35) ? sdt_pkg::FN_DEL_L :
                              (r < 75) ? sdt_pkg::FN_DEL_E :
                              (r < 85) ? sdt_pkg::FN_LOOKUP_L :
                              (r < 95) ? sdt_pkg::FN_LOOKUP_E :
                              sdt_pkg::FN_REPLACE_E;
         default: op.func = (r < 10) ? sdt_pkg::FN_ADD_L :
                            (r < 22) ? sdt_pkg::FN_ADD_E :
                            (r < 30) ? sdt_pkg::FN_DEL_L :
                            (r < 38) ? sdt_pkg::FN_DEL_E :
                            (r < 58) ? sdt_pkg::FN_LOOKUP_L :
                            (r < 80) ? sdt_pkg::FN_LOOKUP_E :
                            sdt_pkg::FN_REPLACE_E;
      endcase
      reuse = ($urandom_range(0, 9) < 7);
      case (op.func)
         sdt_pkg::FN_ADD_L: begin
            op.handle = pick_handle();
            // fill phase: wide tuples so the table really reaches full
            if (mix != MIX_FILL) begin
               op.local_addr = pick_addr();
               op.local_port = pick_port();
            end
         end
         sdt_pkg::FN_ADD_E, sdt_pkg::FN_REPLACE_E: begin
            op.handle      = pick_handle();
            op.local_addr  = pick_addr();
            op.local_port  = pick_port();
            op.remote_addr = pick_addr();
            op.remote_port = pick_port();
            if (op.func == sdt_pkg::FN_REPLACE_E) begin
               if (reuse && estab_used > 0)
                  op.old_handle = estab_shadow[$urandom_range(0, estab_used - 1)].handle;
               else
                  op.old_handle = pick_handle();
            end
         end
         sdt_pkg::FN_DEL_L: begin
            if (reuse && listen_used > 0)
               op.handle = listen_shadow[$urandom_range(0, listen_used - 1)].handle;
            else
               op.handle = pick_handle();
         end
         sdt_pkg::FN_DEL_E: begin
            if (reuse && estab_used > 0)
               op.handle = estab_shadow[$urandom_range(0, estab_used - 1)].handle;
            else
               op.handle = pick_handle();
         end
         sdt_pkg::FN_LOOKUP_L: begin
            op.local_addr = pick_addr();
            op.local_port = pick_port();
            if (reuse && listen_used > 0) begin
               idx = $urandom_range(0, listen_used - 1);
               op.local_port = listen_shadow[idx].port;
               if (listen_shadow[idx].addr != '0 && $urandom_range(0, 1))
                  op.local_addr = listen_shadow[idx].addr;
            end
         end
         sdt_pkg::FN_LOOKUP_E: begin
            op.local_addr  = pick_addr();
            op.local_port  = pick_port();
            op.remote_addr = pick_addr();
            op.remote_port = pick_port();
            if (reuse && estab_used > 0) begin
               idx = $urandom_range(0, estab_used - 1);
               op.local_addr  = estab_shadow[idx].local_addr;
               op.local_port  = estab_shadow[idx].local_port;
               op.remote_addr = estab_shadow[idx].remote_addr;
               op.remote_port = estab_shadow[idx].remote_port;
            end
         end
         default: ;
      endcase
      return op;
   endfunction

   // -------------------------------------------------------------------------
   // Request side: bursts of random length separated by random gaps
   // -------------------------------------------------------------------------
   initial begin
      socket_op_type   op;
      socket_rsp_type  predicted;
      traffic_mix_type mix;
      int              sent;
      int              total;
      int              burst_left;
      int              gap;

      // Directed rows; typed ones carry their own response
      directed_ops.push_back(mk_op(sdt_pkg::FN_LOOKUP_L, 0, 0, 0, 0, 0, 0,
                                   1, sdt_pkg::ST_NOTFOUND, 0));
      directed_ops.push_back(mk_op(sdt_pkg::FN_LOOKUP_E, 0, 0, 0, 0, 0, 0,
                                   1, sdt_pkg::ST_NOTFOUND, 0));
      directed_ops.push_back(mk_op(sdt_pkg::FN_DEL_L, 5, 0, 0, 0, 0, 0,
                                   1, sdt_pkg::ST_NOTFOUND, 0));
      directed_ops.push_back(mk_op(sdt_pkg::FN_DEL_E, 0, 0, 0, 0, 0, 0,
                                   1, sdt_pkg::ST_NOTFOUND, 0));
      directed_ops.push_back(mk_op(sdt_pkg::FN_ADD_L, 0, 0, 1, 80, 0, 0,
                                   1, sdt_pkg::ST_OK, 0));
      directed_ops.push_back(mk_op(sdt_pkg::FN_ADD_L, 16'hFFFF, 0, 0, 16'hFFFF, 0, 0,
                                   1, sdt_pkg::ST_OK, 0));
      // wildcard listener on the same port already covers this address
      directed_ops.push_back(mk_op(sdt_pkg::FN_ADD_L, 1, 0, 32'hFFFF_FFFF, 16'hFFFF,
                                   0, 0, 1, sdt_pkg::ST_EXISTS, 0));
      directed_ops.push_back(mk_op(sdt_pkg::FN_ADD_L, 2, 0, 32'hFFFF_FFFF, 0, 0, 0,
                                   0, sdt_pkg::ST_OK, 0));
      directed_ops.push_back(mk_op(sdt_pkg::FN_LOOKUP_L, 0, 0, 32'h1234_5678, 16'hFFFF,
                                   0, 0, 1, sdt_pkg::ST_OK, 16'hFFFF));
      directed_ops.push_back(mk_op(sdt_pkg::FN_LOOKUP_L, 0, 0, 32'hFFFF_FFFF, 0, 0, 0,
                                   1, sdt_pkg::ST_OK, 2));
      directed_ops.push_back(mk_op(sdt_pkg::FN_LOOKUP_L, 0, 0, 0, 0, 0, 0,
                                   1, sdt_pkg::ST_NOTFOUND, 0));
      directed_ops.push_back(mk_op(sdt_pkg::FN_ADD_E, 16'hFFFF, 0, 32'hFFFF_FFFF,
                                   16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                                   0, sdt_pkg::ST_OK, 0));
      // duplicate handle on a second connection
      directed_ops.push_back(mk_op(sdt_pkg::FN_ADD_E, 16'hFFFF, 0, 0, 0, 0, 0,
                                   0, sdt_pkg::ST_OK, 0));
      directed_ops.push_back(mk_op(sdt_pkg::FN_ADD_E, 0, 0, 5, 5, 5, 5,
                                   1, sdt_pkg::ST_OK, 0));
      directed_ops.push_back(mk_op(sdt_pkg::FN_LOOKUP_E, 0, 0, 32'hFFFF_FFFF, 16'hFFFF,
                                   32'hFFFF_FFFF, 16'hFFFF,
                                   1, sdt_pkg::ST_OK, 16'hFFFF));
      directed_ops.push_back(mk_op(sdt_pkg::FN_LOOKUP_E, 0, 0, 0, 0, 0, 0,
                                   1, sdt_pkg::ST_OK, 16'hFFFF));
      // removes the older of the two entries sharing the handle
      directed_ops.push_back(mk_op(sdt_pkg::FN_DEL_E, 16'hFFFF, 0, 0, 0, 0, 0,
                                   1, sdt_pkg::ST_OK, 0));
      directed_ops.push_back(mk_op(sdt_pkg::FN_LOOKUP_E, 0, 0, 32'hFFFF_FFFF, 16'hFFFF,
                                   32'hFFFF_FFFF, 16'hFFFF,
                                   1, sdt_pkg::ST_NOTFOUND, 0));
      directed_ops.push_back(mk_op(sdt_pkg::FN_REPLACE_E, 3, 16'hFFFF, 1, 2, 3, 4,
                                   0, sdt_pkg::ST_OK, 0));
      // unknown old handle and no new handle: still a clean status
      directed_ops.push_back(mk_op(sdt_pkg::FN_REPLACE_E, 0, 77, 0, 0, 0, 0,
                                   1, sdt_pkg::ST_OK, 0));
      directed_ops.push_back(mk_op(sdt_pkg::FN_LOOKUP_E, 0, 0, 1, 2, 3, 4,
                                   1, sdt_pkg::ST_OK, 3));
      directed_ops.push_back(mk_op(sdt_pkg::FN_DEL_L, 16'hFFFF, 0, 0, 0, 0, 0,
                                   1, sdt_pkg::ST_OK, 0));
      directed_ops.push_back(mk_op(sdt_pkg::FN_LOOKUP_L, 0, 0, 32'h1234_5678, 16'hFFFF,
                                   0, 0, 1, sdt_pkg::ST_NOTFOUND, 0));
      directed_ops.push_back(mk_op(FN_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                   16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                                   1, sdt_pkg::ST_OK, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      sent       = 0;
      total      = directed_ops.size() + RAND_ITEMS;
      burst_left = 0;
      while (sent < total) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 :
                  ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) :
                  $urandom_range(1, 4);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;

         if (sent < directed_ops.size())
            op = directed_ops[sent];
         else begin
            case (((sent - directed_ops.size()) / SEG_LEN) % 4)
               0:       mix = MIX_FILL;
               2:       mix = MIX_DRAIN;
               default: mix = MIX_BALANCED;
            endcase
            op = gen_socket_op(mix);
         end

         req_func        <= op.func;
         req_handle      <= op.handle;
         req_old_handle  <= op.old_handle;
         req_local_addr  <= op.local_addr;
         req_local_port  <= op.local_port;
         req_remote_addr <= op.remote_addr;
         req_remote_port <= op.remote_port;
         req_valid       <= 1'b1;

         // hold the transfer until it is taken
         do @(posedge clock); while (!req_ready);

         predicted = socket_lookup_predict(op);
         if (op.typed)
            pending_rsp.push_back({op.status, op.found_handle});
         else
            pending_rsp.push_back(predicted);
         sent++;
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0)
         @(posedge clock);
      // let any stray response surface before closing
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("[socket_demux_table_core] OK");
      else
         $display("[socket_demux_table_core] ERROR");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Response side: check each transfer, then advance the stall pattern
   // -------------------------------------------------------------------------
   socket_rsp_type oldest_rsp;
   int             stall_phase = 0;
   int             stall_mode  = 0;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response status %0d found_handle %0h",
                     $time, rsp_status, rsp_found_handle);
            error_count++;
         end else begin
            oldest_rsp = pending_rsp.pop_front();
            if (rsp_status !== oldest_rsp.status) begin
               $display("%0t: status mismatch expected %0d actual %0d",
                        $time, oldest_rsp.status, rsp_status);
               error_count++;
            end
            if (rsp_found_handle !== oldest_rsp.found_handle) begin
               $display("%0t: found_handle mismatch expected %0h actual %0h",
                        $time, oldest_rsp.found_handle, rsp_found_handle);
               error_count++;
            end
         end
      end

      // switch stall style each time stall_phase wraps to zero; style zero never stalls
      stall_phase = (stall_phase + 1) % 64;
      if (stall_phase == 0)
         stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         2:       rsp_ready <= (stall_phase % 4 == 0);
         default: rsp_ready <= (stall_phase % 16 >= 12);
      endcase
   end

   // -------------------------------------------------------------------------
   // Watchdog: too long without any transfer ends the run
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("[socket_demux_table_core] ERROR");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

endmodule
